// File: hw/rtl/arl_pkg.sv
package arl_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // internal coordinate width: holds endpoint + 1 without wrap
  localparam int CW = 18;

  localparam int QDEPTH = 4;

  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CLIP_LEFT     = 3'd2;
  localparam logic [2:0] REG_CLIP_TOP      = 3'd3;
  localparam logic [2:0] REG_CLIP_WIDTH    = 3'd4;
  localparam logic [2:0] REG_CLIP_HEIGHT   = 3'd5;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [7:0]           cov;
    logic [15:0]          color;
    logic                 en;
    logic                 last;
    logic                 done;
  } pix_t;

  typedef struct packed {
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic [12:0]        clip_width;
    logic [12:0]        clip_height;
  } cfg_t;

endpackage

// File: hw/rtl/arl_cmd_if.sv
interface arl_cmd_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic [15:0]        line_color;

  modport source (output valid, action, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

// File: hw/rtl/arl_pix_if.sv
interface arl_pix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         coverage;
  logic [15:0]        pixel_color;
  logic               write_enable;
  logic               last_of_run;
  logic               line_done;

  modport source (output valid, pixel_x, pixel_y, coverage, pixel_color, write_enable,
                  last_of_run, line_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, coverage, pixel_color, write_enable,
                last_of_run, line_done, output ready);
endinterface

// File: hw/rtl/antialiased_line_raster.sv
// flow: a start word pushes its pixels from S_START for straight lines or an empty clip,
// and from S_E0 to S_E3 after the one-bit-per-cycle divider for general ones; a step
// word pushes from S_STEP0, plus S_STEP1 for the second pixel of a general line; pushes
// wait while the queue is full, the output is registered, and a new word is taken in S_IDLE
// reset: synchronous, clears line state, queue and output; config back to 320x240
module antialiased_line_raster import arl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  arl_cmd_if.sink     cmd,
  arl_pix_if.source   pix,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  logic clip_empty;
  logic push, full, pop, nonempty;
  pix_t push_word, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd320;
      cfg.screen_height <= 13'd240;
      cfg.clip_left     <= '0;
      cfg.clip_top      <= '0;
      cfg.clip_width    <= 13'd320;
      cfg.clip_height   <= 13'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[12:0];
        REG_CLIP_LEFT:     cfg.clip_left     <= cfg_data;
        REG_CLIP_TOP:      cfg.clip_top      <= cfg_data;
        REG_CLIP_WIDTH:    cfg.clip_width    <= cfg_data[12:0];
        REG_CLIP_HEIGHT:   cfg.clip_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign clip_empty = (cfg.clip_width == '0) || (cfg.clip_height == '0);

  arl_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .clip_empty (clip_empty),
    .push       (push),
    .push_word  (push_word),
    .full       (full)
  );

  arl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_word),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rdata    (head)
  );

  arl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .nonempty (nonempty),
    .word     (head),
    .pop      (pop),
    .pix      (pix)
  );

endmodule

// File: hw/rtl/arl_front.sv
module arl_front import arl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  arl_cmd_if.sink    cmd,
  input  logic       clip_empty,
  output logic       push,
  output pix_t       push_word,
  input  logic       full
);

  localparam int AW    = CW + FRAC_BITS + 1;
  localparam int NW    = 17 + FRAC_BITS;
  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_E0    = 4'd3;
  localparam logic [3:0] S_E1    = 4'd4;
  localparam logic [3:0] S_E2    = 4'd5;
  localparam logic [3:0] S_E3    = 4'd6;
  localparam logic [3:0] S_STEP0 = 4'd7;
  localparam logic [3:0] S_STEP1 = 4'd8;

  logic [3:0]                state;
  logic                      active;
  logic                      steep;
  logic                      straight_mode;
  logic signed [CW-1:0]      cur_major;
  logic signed [CW-1:0]      last_major;
  logic signed [AW-1:0]      minor_accum;
  logic signed [FRAC_BITS+1:0] slope;
  logic [15:0]               held_color;
  logic signed [CW-1:0]      x0, y0, x1, y1;
  logic [15:0]               dmag;
  logic                      dneg;
  logic [15:0]               rem;
  logic [QW-1:0]             low;
  logic [QW-1:0]             quo;
  logic [CNT_W-1:0]          cnt;

  function automatic logic signed [CW-1:0] sext(input logic [15:0] v);
    sext = {{(CW-COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]};
  endfunction

  function automatic pix_t mk(input logic st, input logic [15:0] col,
                              input logic signed [CW-1:0] ma, input logic signed [CW-1:0] mi,
                              input logic [7:0] cov, input logic en, input logic last,
                              input logic done);
    pix_t p;
    p.x     = st ? mi : ma;
    p.y     = st ? ma : mi;
    p.cov   = cov;
    p.color = col;
    p.en    = en;
    p.last  = last;
    p.done  = done;
    mk = p;
  endfunction

  // start classification
  logic signed [CW-1:0] ddx, ddy, adx, ady;
  logic                 gsteep;
  logic signed [CW-1:0] a0, b0, a1, b1, oa0, ob0, oa1, ob1, gdy;
  logic [15:0]          gdx_mag, gdy_mag;
  logic [NW-1:0]        num;
  logic                 line_straight, sst;
  logic signed [CW-1:0] s_minor, s_cur, s_last;

  always_comb begin
    ddx = x1 - x0;
    ddy = y1 - y0;
    adx = ddx[CW-1] ? -ddx : ddx;
    ady = ddy[CW-1] ? -ddy : ddy;
    gsteep = ady > adx;
    a0 = gsteep ? y0 : x0;
    b0 = gsteep ? x0 : y0;
    a1 = gsteep ? y1 : x1;
    b1 = gsteep ? x1 : y1;
    if (a0 > a1) begin
      oa0 = a1; ob0 = b1; oa1 = a0; ob1 = b0;
    end else begin
      oa0 = a0; ob0 = b0; oa1 = a1; ob1 = b1;
    end
    gdx_mag = 16'(oa1 - oa0);
    gdy     = ob1 - ob0;
    gdy_mag = gdy[CW-1] ? 16'(-gdy) : 16'(gdy);
    num = {1'b0, gdy_mag, {FRAC_BITS{1'b0}}} + NW'(gdx_mag >> 1);
    line_straight = (x0 == x1) || (y0 == y1);
    sst     = (y0 != y1);
    s_minor = sst ? x0 : y0;
    s_cur   = sst ? ((y0 < y1) ? y0 : y1) : ((x0 < x1) ? x0 : x1);
    s_last  = sst ? ((y0 < y1) ? y1 : y0) : ((x0 < x1) ? x1 : x0);
  end

  // step pixel values
  logic signed [AW-1:0]   ishift;
  logic signed [CW-1:0]   yfl;
  logic [FRAC_BITS-1:0]   frac;
  logic [FRAC_BITS:0]     compl;
  logic [FRAC_BITS+7:0]   w2;
  logic [FRAC_BITS+8:0]   w1;
  logic [7:0]             alpha1, alpha2;
  logic [QW:0]            trial;
  logic                   ge;
  logic signed [CW-1:0]   cur_inc;

  always_comb begin
    ishift = minor_accum >>> FRAC_BITS;
    yfl    = ishift[CW-1:0];
    frac   = minor_accum[FRAC_BITS-1:0];
    compl  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    w2     = {frac, 8'h00} - (FRAC_BITS+8)'(frac);
    w1     = {compl, 8'h00} - (FRAC_BITS+9)'(compl);
    alpha2 = w2[FRAC_BITS+7:FRAC_BITS];
    alpha1 = w1[FRAC_BITS+7:FRAC_BITS];
    trial  = (QW+1)'({rem, low[QW-1]});
    ge     = trial >= (QW+1)'(dmag);
    cur_inc = cur_major + CW'(1);
  end

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    push      = 1'b0;
    push_word = mk(steep, held_color, cur_major, yfl, alpha1, 1'b1, 1'b0, 1'b0);
    unique case (state)
      S_START: begin
        if (clip_empty) begin
          push      = 1'b1;
          push_word = mk(1'b0, held_color, x0, y0, 8'd0, 1'b0, 1'b1, 1'b1);
        end else if (line_straight) begin
          push      = 1'b1;
          push_word = mk(sst, held_color, s_cur, s_minor, 8'd255, 1'b1, 1'b1,
                         !((s_cur + CW'(1)) <= s_last));
        end
      end
      S_E0: begin
        push      = 1'b1;
        push_word = mk(steep, held_color, x0, y0, 8'd127, 1'b1, 1'b0, 1'b0);
      end
      S_E1: begin
        push      = 1'b1;
        push_word = mk(steep, held_color, x0, y0 + CW'(1), 8'd0, 1'b1, 1'b0, 1'b0);
      end
      S_E2: begin
        push      = 1'b1;
        push_word = mk(steep, held_color, x1, y1, 8'd127, 1'b1, 1'b0, 1'b0);
      end
      S_E3: begin
        push      = 1'b1;
        push_word = mk(steep, held_color, x1, y1 + CW'(1), 8'd0, 1'b1, 1'b1,
                       !((x0 + CW'(1)) < x1));
      end
      S_STEP0: begin
        push = 1'b1;
        if (straight_mode)
          push_word = mk(steep, held_color, cur_major, minor_accum[CW-1:0], 8'd255,
                         1'b1, 1'b1, !(cur_inc <= last_major));
        else
          push_word = mk(steep, held_color, cur_major, yfl, alpha1, 1'b1, 1'b0, 1'b0);
      end
      S_STEP1: begin
        push      = 1'b1;
        push_word = mk(steep, held_color, cur_major, yfl + CW'(1), alpha2, 1'b1, 1'b1,
                       !(cur_inc < last_major));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= 1'b0;
      steep         <= 1'b0;
      straight_mode <= 1'b0;
      cur_major     <= '0;
      last_major    <= '0;
      minor_accum   <= '0;
      slope         <= '0;
      held_color    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.action == ACT_START) begin
              x0         <= sext(cmd.start_x);
              y0         <= sext(cmd.start_y);
              x1         <= sext(cmd.end_x);
              y1         <= sext(cmd.end_y);
              held_color <= cmd.line_color;
              active     <= 1'b0;
              state      <= S_START;
            end else if (active) begin
              state <= S_STEP0;
            end
          end
        end
        S_START: begin
          if (clip_empty) begin
            if (!full) begin
              steep <= 1'b0;
              state <= S_IDLE;
            end
          end else if (line_straight) begin
            if (!full) begin
              straight_mode <= 1'b1;
              steep         <= sst;
              minor_accum   <= AW'(s_minor);
              cur_major     <= s_cur + CW'(1);
              last_major    <= s_last;
              active        <= (s_cur + CW'(1)) <= s_last;
              state         <= S_IDLE;
            end
          end else begin
            straight_mode <= 1'b0;
            steep         <= gsteep;
            x0            <= oa0;
            y0            <= ob0;
            x1            <= oa1;
            y1            <= ob1;
            dmag          <= gdx_mag;
            dneg          <= gdy[CW-1];
            rem           <= num[NW-1:QW];
            low           <= num[QW-1:0];
            cnt           <= '0;
            state         <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          rem <= ge ? 16'(trial - (QW+1)'(dmag)) : 16'(trial);
          low <= {low[QW-2:0], 1'b0};
          quo <= {quo[QW-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(QW-1)) state <= S_E0;
        end
        S_E0: if (!full) state <= S_E1;
        S_E1: if (!full) state <= S_E2;
        S_E2: if (!full) state <= S_E3;
        S_E3: begin
          if (!full) begin
            slope       <= dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
            minor_accum <= ($signed(AW'(y0)) <<< FRAC_BITS) +
                           (dneg ? -$signed(AW'(quo)) : $signed(AW'(quo)));
            cur_major   <= x0 + CW'(1);
            last_major  <= x1;
            active      <= (x0 + CW'(1)) < x1;
            state       <= S_IDLE;
          end
        end
        S_STEP0: begin
          if (!full) begin
            if (straight_mode) begin
              cur_major <= cur_inc;
              active    <= cur_inc <= last_major;
              state     <= S_IDLE;
            end else begin
              state <= S_STEP1;
            end
          end
        end
        S_STEP1: begin
          if (!full) begin
            minor_accum <= minor_accum + AW'(slope);
            cur_major   <= cur_inc;
            active      <= cur_inc < last_major;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/arl_fifo.sv
module arl_fifo import arl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t wdata,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output pix_t rdata
);

  localparam int PW = $clog2(QDEPTH);

  pix_t          mem [QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == (PW+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

// File: hw/rtl/arl_back.sv
module arl_back import arl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      nonempty,
  input  pix_t      word,
  output logic      pop,
  arl_pix_if.source pix
);

  logic signed [18:0] xs, ys, cl, ct, cr, cb, sw, sh;
  logic               vis;

  always_comb begin
    xs  = 19'(word.x);
    ys  = 19'(word.y);
    sw  = $signed({6'b0, cfg.screen_width});
    sh  = $signed({6'b0, cfg.screen_height});
    cl  = 19'(cfg.clip_left);
    ct  = 19'(cfg.clip_top);
    cr  = cl + $signed({6'b0, cfg.clip_width});
    cb  = ct + $signed({6'b0, cfg.clip_height});
    vis = (xs >= 0) && (ys >= 0) && (xs < sw) && (ys < sh) &&
          (xs >= cl) && (xs < cr) && (ys >= ct) && (ys < cb);
  end

  assign pop = nonempty && (!pix.valid || pix.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix.ready) begin
      pix.valid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix.pixel_x      <= word.x[15:0];
      pix.pixel_y      <= word.y[15:0];
      pix.coverage     <= word.cov;
      pix.pixel_color  <= word.color;
      pix.write_enable <= word.en && vis;
      pix.last_of_run  <= word.last;
      pix.line_done    <= word.done;
    end
  end

endmodule

// File: bench/arl_tb_if.sv
// the block's own channel interfaces are used; this file carries the config bundle
interface arl_cfg_bus;
  logic        we;
  logic [2:0]  index;
  logic [15:0] data;
endinterface

// File: bench/antialiased_line_raster_checker.sv
module antialiased_line_raster_checker import arl_pkg::*; (
  input logic   clk,
  input logic   rst,
  arl_cmd_if    cmd,
  arl_pix_if    pix,
  arl_cfg_bus   cfg,
  output int    errors,
  output int    pending,
  output int    pixels_seen,
  output int    lines_started
);
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  cov;
    logic [15:0] color;
    logic        en;
    logic        last;
    logic        done;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [12:0] scr_w, scr_h, clip_w, clip_h;
  logic signed [15:0] clip_l, clip_t;
  logic line_active, line_steep, line_straight;
  longint major_pos, major_end, minor_acc, gradient;
  logic [15:0] line_rgb;
  pixel_t batch[4];
  int nb;

  function automatic bit on_screen(longint px, longint py);
    if (px < 0 || py < 0 || px >= longint'(scr_w) || py >= longint'(scr_h)) return 0;
    if (px < clip_l || px >= longint'(clip_l) + longint'(clip_w)) return 0;
    if (py < clip_t || py >= longint'(clip_t) + longint'(clip_h)) return 0;
    return 1;
  endfunction

  task automatic emit(longint mj, longint mn, int cov, bit en);
    longint px, py;
    pixel_t p;
    px = line_steep ? mn : mj;
    py = line_steep ? mj : mn;
    p.x = px[15:0];
    p.y = py[15:0];
    p.cov = cov[7:0];
    p.color = line_rgb;
    p.en = en && on_screen(px, py);
    p.last = 0;
    p.done = 0;
    batch[nb] = p;
    nb++;
  endtask

  task automatic flush_batch();
    batch[nb-1].last = 1;
    batch[nb-1].done = !line_active;
    for (int i = 0; i < nb; i++) expected_pixels.push_back(batch[i]);
  endtask

  task automatic predict_word(logic act, longint x0, longint y0, longint x1, longint y1,
                              logic [15:0] rgb);
    longint t, dx, dy, q, fr, fy;
    nb = 0;
    if (act == ACT_START) begin
      line_rgb = rgb;
      line_active = 0;
      lines_started++;
      if (clip_w == 0 || clip_h == 0) begin
        line_steep = 0;
        emit(x0, y0, 0, 0);
      end else if (y0 == y1 || x0 == x1) begin
        line_straight = 1;
        line_steep = (y0 != y1);
        if (line_steep) begin
          minor_acc = x0;
          major_pos = y0 < y1 ? y0 : y1;
          major_end = y0 < y1 ? y1 : y0;
        end else begin
          minor_acc = y0;
          major_pos = x0 < x1 ? x0 : x1;
          major_end = x0 < x1 ? x1 : x0;
        end
        emit(major_pos, minor_acc, 255, 1);
        major_pos++;
        line_active = major_pos <= major_end;
      end else begin
        line_straight = 0;
        line_steep = ((y1 > y0) ? y1 - y0 : y0 - y1) > ((x1 > x0) ? x1 - x0 : x0 - x1);
        if (line_steep) begin
          t = x0; x0 = y0; y0 = t;
          t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        q = (((dy < 0 ? -dy : dy) <<< 16) + dx / 2) / dx;
        gradient = dy < 0 ? -q : q;
        emit(x0, y0, 127, 1);
        emit(x0, y0 + 1, 0, 1);
        emit(x1, y1, 127, 1);
        emit(x1, y1 + 1, 0, 1);
        minor_acc = y0 * 65536 + gradient;
        major_pos = x0 + 1;
        major_end = x1;
        line_active = major_pos < major_end;
      end
      flush_batch();
    end else if (line_active) begin
      if (line_straight) begin
        emit(major_pos, minor_acc, 255, 1);
        major_pos++;
        line_active = major_pos <= major_end;
      end else begin
        fy = minor_acc >>> 16;
        fr = minor_acc & 64'hFFFF;
        emit(major_pos, fy, ((65536 - fr) * 255) >> 16, 1);
        emit(major_pos, fy + 1, (fr * 255) >> 16, 1);
        minor_acc += gradient;
        major_pos++;
        line_active = major_pos < major_end;
      end
      flush_batch();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scr_w <= 320; scr_h <= 240; clip_l <= 0; clip_t <= 0; clip_w <= 320; clip_h <= 240;
      line_active = 0; line_steep = 0; line_straight = 0;
      major_pos = 0; major_end = 0; minor_acc = 0; gradient = 0; line_rgb = 0;
      expected_pixels.delete();
      errors <= 0;
      pixels_seen <= 0;
      lines_started = 0;
    end else begin
      if (cfg.we) begin
        case (cfg.index)
          REG_SCREEN_WIDTH:  scr_w <= cfg.data[12:0];
          REG_SCREEN_HEIGHT: scr_h <= cfg.data[12:0];
          REG_CLIP_LEFT:     clip_l <= cfg.data;
          REG_CLIP_TOP:      clip_t <= cfg.data;
          REG_CLIP_WIDTH:    clip_w <= cfg.data[12:0];
          REG_CLIP_HEIGHT:   clip_h <= cfg.data[12:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        predict_word(cmd.action, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
                     cmd.line_color);
      if (pix.valid && pix.ready) begin
        pixel_t got;
        got = {pix.pixel_x, pix.pixel_y, pix.coverage, pix.pixel_color, pix.write_enable,
               pix.last_of_run, pix.line_done};
        pixels_seen <= pixels_seen + 1;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel word, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          pixel_t want;
          want = expected_pixels.pop_front();
          if (want !== got) begin
            $display("%0t: pixel mismatch expected x=%0d y=%0d cov=%0d col=%h we=%b l=%b d=%b",
                     $time, $signed(want.x), $signed(want.y), want.cov, want.color, want.en,
                     want.last, want.done);
            $display("%0t:                actual x=%0d y=%0d cov=%0d col=%h we=%b l=%b d=%b",
                     $time, $signed(got.x), $signed(got.y), got.cov, got.color, got.en,
                     got.last, got.done);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_pixels.size();
endmodule

// File: bench/antialiased_line_raster_tb.sv
module antialiased_line_raster_tb import arl_pkg::*;;
  logic clk, rst;
  int errors, pending, pixels_seen, lines_started, cycle_count;
  logic hold_off;
  int burst_left, gap_left;

  arl_cmd_if  cmd();
  arl_pix_if  pix();
  arl_cfg_bus cfg();

  antialiased_line_raster uut (
    .clk(clk), .rst(rst), .cmd(cmd), .pix(pix),
    .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
  );

  antialiased_line_raster_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd), .pix(pix), .cfg(cfg),
    .errors(errors), .pending(pending), .pixels_seen(pixels_seen),
    .lines_started(lines_started)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst) pix.ready <= 0;
    else if (hold_off) pix.ready <= 0;
    else pix.ready <= ($urandom_range(0, 3) != 0) || (cycle_count[10:9] == 2'b01);
  end

  initial begin
    hold_off = 0;
    wait (cycle_count > 600);
    @(posedge clk);
    hold_off <= 1;
    repeat (300) @(posedge clk);
    hold_off <= 0;
  end

  always @(posedge clk) begin
    if (rst) cycle_count <= 0;
    else cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("antialiased_line_raster_tb failed");
      $finish;
    end
  end

  task automatic send_word(logic act, logic [15:0] x0, logic [15:0] y0, logic [15:0] x1,
                           logic [15:0] y1, logic [15:0] rgb);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      repeat (gap_left) @(posedge clk);
    end
    burst_left--;
    cmd.valid <= 1;
    cmd.action <= act;
    cmd.start_x <= x0;
    cmd.start_y <= y0;
    cmd.end_x <= x1;
    cmd.end_y <= y1;
    cmd.line_color <= rgb;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (burst_left == 0) cmd.valid <= 0;
  endtask

  task automatic drain();
    cmd.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg.we <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    cfg.we <= 0;
  endtask

  task automatic set_view(int sw, int sh, int cl, int ct, int cw, int ch);
    write_reg(REG_SCREEN_WIDTH, 16'(sw));
    write_reg(REG_SCREEN_HEIGHT, 16'(sh));
    write_reg(REG_CLIP_LEFT, 16'(cl));
    write_reg(REG_CLIP_TOP, 16'(ct));
    write_reg(REG_CLIP_WIDTH, 16'(cw));
    write_reg(REG_CLIP_HEIGHT, 16'(ch));
  endtask

  function automatic logic [15:0] pick_coord(bit near);
    if (near) return 16'($urandom_range(0, 80) - 20);
    return 16'($urandom_range(0, 65535));
  endfunction

  // a start with short random length (or, one time in ten, random far endpoints), then its steps, sometimes cut short
  task automatic random_line(int budget, ref int words);
    logic [15:0] x0, y0, x1, y1;
    int kind, steps;
    kind = $urandom_range(0, 9);
    x0 = pick_coord(kind != 0);
    y0 = pick_coord(kind != 0);
    x1 = 16'(x0 + $urandom_range(0, 40) - 20);
    y1 = 16'(y0 + $urandom_range(0, 40) - 20);
    if (kind == 1) y1 = y0;
    if (kind == 2) x1 = x0;
    if (kind == 0) begin
      x1 = pick_coord(0);
      y1 = pick_coord(0);
    end
    send_word(ACT_START, x0, y0, x1, y1, 16'($urandom));
    words++;
    steps = (kind == 0) ? $urandom_range(0, 4) : $urandom_range(0, 44);
    if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, 3);
    for (int i = 0; i < steps && words < budget; i++) begin
      send_word(ACT_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
      words++;
    end
  endtask

  initial begin
    int words;
    rst = 1;
    cmd.valid = 0; cmd.action = ACT_START;
    cmd.start_x = 0; cmd.start_y = 0; cmd.end_x = 0; cmd.end_y = 0; cmd.line_color = 0;
    cfg.we = 0; cfg.index = REG_SCREEN_WIDTH; cfg.data = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: idle step, point, straight, general, abandon, extremes
    send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 5, 5, 5, 5, 16'hFFFF);
    send_word(ACT_START, 10, 3, 13, 3, 16'h1234);
    repeat (4) send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 7, 20, 7, 16, 16'h0F0F);
    repeat (4) send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 0, 0, 1, 1, 16'hA5A5);
    send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 30, 10, 2, 25, 16'h5A5A);
    repeat (3) send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 4, 40, 9, 2, 16'h0001);
    repeat (2) send_word(ACT_STEP, 0, 0, 0, 0, 0);
    send_word(ACT_START, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    send_word(ACT_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_START, 16'h8000, 100, 16'h7FFF, 100, 16'h7E0F);
    send_word(ACT_STEP, 0, 0, 0, 0, 0);
    drain();

    set_view(1, 1, 0, 0, 0, 240);
    send_word(ACT_START, 3, 4, 9, 1, 16'hBEEF);
    send_word(ACT_STEP, 0, 0, 0, 0, 0);
    drain();

    words = 0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_view(320, 240, 0, 0, 320, 240);
        1: set_view(4096, 4096, 16'h8000, 16'h8000, 4096, 4096);
        2: set_view(40, 30, 5, 4, 20, 10);
        3: set_view(4096, 4096, 16'h7FFF, 16'hFFF0, 4096, 4096);
        default: set_view(64, 64, 16'hFFFC, 2, 4096, 0);
      endcase
      while (words < 90 * (phase + 1)) random_line(90 * (phase + 1), words);
      drain();
    end

    $display("covered %0d line starts, %0d pixel words checked over five clip settings",
             lines_started, pixels_seen);
    if (errors == 0) $display("antialiased_line_raster_tb passed");
    else $display("antialiased_line_raster_tb failed");
    $finish;
  end
endmodule
